// ----- src/cbm_pkg.sv -----
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int unsigned MAX_ROM_BANKS      = 128;
  localparam int unsigned ROM_BANK_BYTES     = 16384;
  localparam int unsigned MAX_RAM_BANKS      = 4;
  localparam int unsigned RAM_BANK_MAX_BYTES = 8192;

  localparam int unsigned ROM_BYTES = MAX_ROM_BANKS * ROM_BANK_BYTES;
  localparam int unsigned RAM_BYTES = MAX_RAM_BANKS * RAM_BANK_MAX_BYTES;
  localparam int unsigned ROM_AW    = $clog2(ROM_BYTES);
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);
  localparam int unsigned RAM_OFF_W = $clog2(RAM_BANK_MAX_BYTES);
  localparam int unsigned ROM_OFF_W = $clog2(ROM_BANK_BYTES);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  localparam int unsigned Q_DEPTH = 2;

  localparam logic [7:0]  ROM_BANKS_RST = 8'd2;
  localparam logic [2:0]  RAM_BANKS_RST = 3'd0;
  localparam logic [13:0] RAM_BYTES_RST = 14'd8192;
  localparam logic [7:0]  BIG_ROM_BANKS = 8'd32;
  localparam logic [3:0]  RAM_EN_KEY    = 4'hA;
  localparam logic [7:0]  OPEN_BUS      = 8'hFF;

  typedef enum logic [1:0] {
    REG_ROM_BANKS = 2'd0,
    REG_RAM_BANKS = 2'd1,
    REG_RAM_BYTES = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OP_ROM_RD,
    OP_RAM_RD,
    OP_OPEN_RD,
    OP_ROM_WR,
    OP_RAM_WR
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ROM_AW-1:0] addr;
    logic [7:0]       data;
  } q_entry_t;

endpackage

// ----- src/cbm_ram.sv -----
`timescale 1ns / 1ps

module cbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- src/cbm_front.sv -----
`timescale 1ns / 1ps

module cbm_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       req_type_i,
  input  logic [15:0]                      bus_address_i,
  input  logic [7:0]                       write_byte_i,
  input  logic [20:0]                      load_index_i,
  input  logic                             clearing_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output cbm_pkg::q_entry_t                q_entry_o
);
  import cbm_pkg::*;

  logic [7:0]  rom_banks_q;
  logic [2:0]  ram_banks_q;
  logic [13:0] ram_bytes_q;
  logic        ram_on_q, ram_on_d;
  logic [4:0]  prim_q, prim_d;
  logic [1:0]  sec_q, sec_d;
  logic        mode_q, mode_d;

  logic                 accept;
  logic                 push;
  logic [7:0]           rom_mask;
  logic [13:0]          ram_size_mask;
  logic                 big_rom;
  logic                 multi_ram;
  logic                 ram_ok;
  logic                 ram_win;
  logic [RAM_OFF_W-1:0] ram_off;
  logic [RAM_AW-1:0]    ram_idx;
  logic [6:0]           rom_bank;
  logic [4:0]           wr_low5;

  assign in_ready_o = !clearing_i && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign rom_mask      = rom_banks_q - 8'd1;
  assign ram_size_mask = ram_bytes_q - 14'd1;
  assign big_rom       = rom_banks_q > BIG_ROM_BANKS;
  assign multi_ram     = ram_banks_q > 3'd1;
  assign ram_ok        = ram_on_q && (ram_banks_q != 3'd0);
  assign ram_win       = bus_address_i[15:13] == 3'b101;
  assign ram_off       = bus_address_i[RAM_OFF_W-1:0] & ram_size_mask[RAM_OFF_W-1:0];
  assign ram_idx       = {(multi_ram ? sec_q : 2'b00), ram_off};
  assign wr_low5       = write_byte_i[4:0];

  // fixed window follows the secondary bank only on large carts
  always_comb begin
    if (bus_address_i[14]) begin
      rom_bank = big_rom ? {sec_q, prim_q} : {2'b00, prim_q};
    end else begin
      rom_bank = big_rom ? {sec_q, 5'b00000} : 7'd0;
    end
  end

  always_comb begin
    push           = 1'b0;
    q_entry_o.op   = OP_OPEN_RD;
    q_entry_o.addr = '0;
    q_entry_o.data = write_byte_i;
    unique case (req_e'(req_type_i))
      REQ_READ: begin
        push = 1'b1;
        if (ram_win) begin
          q_entry_o.op   = ram_ok ? OP_RAM_RD : OP_OPEN_RD;
          q_entry_o.addr = ROM_AW'(ram_idx);
        end else if (bus_address_i[15]) begin
          q_entry_o.op = OP_OPEN_RD;
        end else begin
          q_entry_o.op   = OP_ROM_RD;
          q_entry_o.addr = {rom_bank, bus_address_i[ROM_OFF_W-1:0]};
        end
      end
      REQ_WRITE: begin
        push           = ram_win && ram_ok;
        q_entry_o.op   = OP_RAM_WR;
        q_entry_o.addr = ROM_AW'(ram_idx);
      end
      REQ_LOAD: begin
        push           = 1'b1;
        q_entry_o.op   = OP_ROM_WR;
        q_entry_o.addr = load_index_i[ROM_AW-1:0];
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign q_push_o = accept && push;

  // bank register writes in the 0x0000-0x7fff window
  always_comb begin
    ram_on_d = ram_on_q;
    prim_d   = prim_q;
    sec_d    = sec_q;
    mode_d   = mode_q;
    if (accept && (req_e'(req_type_i) == REQ_WRITE) && !bus_address_i[15]) begin
      unique case (bus_address_i[14:13])
        2'b00: ram_on_d = write_byte_i[3:0] == RAM_EN_KEY;
        2'b01: prim_d = (wr_low5 == 5'd0) ? 5'd1 : (wr_low5 & rom_mask[4:0]);
        2'b10: begin
          if (big_rom) begin
            sec_d = write_byte_i[1:0] & rom_mask[6:5];
          end else if (multi_ram) begin
            sec_d = write_byte_i[1:0];
          end
        end
        default: begin
          if (big_rom || multi_ram) begin
            mode_d = write_byte_i[0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_banks_q <= ROM_BANKS_RST;
      ram_banks_q <= RAM_BANKS_RST;
      ram_bytes_q <= RAM_BYTES_RST;
      ram_on_q    <= 1'b0;
      prim_q      <= 5'd1;
      sec_q       <= 2'd0;
      mode_q      <= 1'b0;
    end else begin
      ram_on_q <= ram_on_d;
      prim_q   <= prim_d;
      sec_q    <= sec_d;
      mode_q   <= mode_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_ROM_BANKS: rom_banks_q <= cfg_wdata_i[7:0];
          REG_RAM_BANKS: ram_banks_q <= cfg_wdata_i[2:0];
          REG_RAM_BYTES: ram_bytes_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- src/cbm_queue.sv -----
`timescale 1ns / 1ps

module cbm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cbm_pkg::q_entry_t entry_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output cbm_pkg::q_entry_t entry_o
);
  import cbm_pkg::*;

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t          slot_q [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- src/cbm_back.sv -----
`timescale 1ns / 1ps

module cbm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cbm_pkg::q_entry_t q_entry_i,
  output logic              q_pop_o,
  output logic              clearing_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_data_o
);
  import cbm_pkg::*;

  logic                 clr_busy_q;
  logic [RAM_AW-1:0]    clr_cnt_q;
  logic                 pend_q;
  op_e                  pend_op_q;
  logic                 out_vld_q, out_vld_d;
  logic [7:0]           out_data_q;

  logic                 is_rd, is_wr;
  logic                 issue_rd, issue_wr;
  logic                 rom_we, ram_we;
  logic [RAM_AW-1:0]    ram_addr;
  logic [7:0]           ram_wdata;
  logic [7:0]           rom_rdata, ram_rdata;

  assign is_rd = (q_entry_i.op == OP_ROM_RD) || (q_entry_i.op == OP_RAM_RD) ||
                 (q_entry_i.op == OP_OPEN_RD);
  assign is_wr = (q_entry_i.op == OP_ROM_WR) || (q_entry_i.op == OP_RAM_WR);

  // a read issues only when the output register will be free to take its data
  assign issue_rd = q_valid_i && is_rd && !clr_busy_q && !pend_q &&
                    (!out_vld_q || out_ready_i);
  assign issue_wr = q_valid_i && is_wr && !clr_busy_q;
  assign q_pop_o  = issue_rd || issue_wr;

  assign rom_we    = issue_wr && (q_entry_i.op == OP_ROM_WR);
  assign ram_we    = clr_busy_q || (issue_wr && (q_entry_i.op == OP_RAM_WR));
  assign ram_addr  = clr_busy_q ? clr_cnt_q : q_entry_i.addr[RAM_AW-1:0];
  assign ram_wdata = clr_busy_q ? 8'd0 : q_entry_i.data;

  cbm_ram #(
    .WIDTH (8),
    .DEPTH (ROM_BYTES)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (rom_we),
    .addr_i  (q_entry_i.addr),
    .wdata_i (q_entry_i.data),
    .rdata_o (rom_rdata)
  );

  cbm_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_xram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (pend_q) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      unique case (pend_op_q)
        OP_ROM_RD: out_data_q <= rom_rdata;
        OP_RAM_RD: out_data_q <= ram_rdata;
        default:   out_data_q <= OPEN_BUS;
      endcase
    end
    if (issue_rd) begin
      pend_op_q <= q_entry_i.op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          clr_busy_q <= 1'b0;
        end
      end
      pend_q    <= issue_rd;
      out_vld_q <= out_vld_d;
    end
  end

  assign clearing_o  = clr_busy_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- src/cartridge_bank_mapper_top.sv -----
`timescale 1ns / 1ps

// Cartridge bank mapper for an 8-bit handheld bus.
// Slave stream: one bus access per beat; tuser carries the request kind
// (read, write, ROM image load, none) and tdata carries address, data byte
// and ROM load index. Master stream: one beat with the read byte for each
// read request; writes, loads and the "none" kind return nothing.
// Configuration is a plain write port (ROM bank count, RAM bank count,
// RAM bank size); the user must write it only while the mapper is idle (unchecked).
// The front decodes each beat and updates the bank registers in the cycle of
// acceptance; a two-entry queue hands memory operations to the back, which
// owns the ROM and RAM arrays (one synchronous port each).
// A read's byte reaches the master side after the read leaves the queue, is
// issued to the arrays and is captured in the output register. Writes and
// loads issue without waiting for a pending read; the back holds the next
// read until the registered array read of the previous one is captured. When
// the receiver stalls, the output register holds its beat, the queue fills
// and the slave tready drops. After reset, tready stays low while all 32768
// external RAM bytes are swept to zero, one byte a cycle; the ROM image is kept.

module cartridge_bank_mapper_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // bus_address, write_byte, load_index, pad
  input  logic [1:0]                     s_axis_tuser,  // req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata   // read_byte
);
  import cbm_pkg::*;

  logic     clearing;
  logic     q_full, q_push, q_valid, q_pop;
  q_entry_t q_in, q_out;

  cbm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .req_type_i    (s_axis_tuser),
    .bus_address_i (s_axis_tdata[15:0]),
    .write_byte_i  (s_axis_tdata[23:16]),
    .load_index_i  (s_axis_tdata[44:24]),
    .clearing_i    (clearing),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  cbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (q_out)
  );

  cbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready)
    else $error("input taken during ram clear");

  a_push_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_pop_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  a_clear_blocks_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !q_pop && !q_valid)
    else $error("back active during ram clear");

endmodule
